// ===== design/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared parse phases, record layout, status and meta codes.
// ----------------------------------------------------------------------------
package mtep_pkg;

  typedef enum logic [3:0] {
    PH_DELTA_FIRST = 4'd0,
    PH_DELTA_MORE  = 4'd1,
    PH_STATUS      = 4'd2,
    PH_DATA1       = 4'd3,
    PH_DATA2       = 4'd4,
    PH_META_TYPE   = 4'd5,
    PH_META_LEN    = 4'd6,
    PH_META_BODY   = 4'd7,
    PH_SKIP        = 4'd8,
    PH_SYSEX_LEN   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_TEMPO   = 2'd1,
    KIND_TIMESIG = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_t;

  localparam int unsigned LEN_WIDTH = 28;

  // status bytes
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_MTC_QF    = 8'hF1;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [3:0] HI_SYSTEM    = 4'hF;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CH_PRESS  = 4'hD;
  localparam logic [3:0] HI_BEND      = 4'hE;

  // meta types
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_TIMESIG = 8'h58;

  localparam logic [4:0] NO_SOLE      = 5'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] track_tag;
    logic [7:0]  status;
    logic [3:0]  channel;
    logic [13:0] first_value;
    logic [6:0]  second_value;
    logic [23:0] aux_value;
    logic [27:0] delta_ticks;
    logic [31:0] absolute_ticks;
    logic [4:0]  sole_channel;
    logic        last_of_run;
  } rec_t;

  // records produced by one byte, towards the output queue
  typedef struct packed {
    logic push0;
    logic push1;
    rec_t rec0;
    rec_t rec1;
  } push_t;

endpackage

// ===== design/mtep_if.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser channels
// Byte input channel and record output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mtep_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        track_start;
  logic        track_end;
  logic [15:0] track_id;

  modport source (output valid, data_byte, track_start, track_end, track_id,
                  input ready);
  modport sink   (input valid, data_byte, track_start, track_end, track_id,
                  output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] track_tag;
  logic [7:0]  status;
  logic [3:0]  channel;
  logic [13:0] first_value;
  logic [6:0]  second_value;
  logic [23:0] aux_value;
  logic [27:0] delta_ticks;
  logic [31:0] absolute_ticks;
  logic [4:0]  sole_channel;
  logic        last_of_run;

  modport source (output valid, kind, track_tag, status, channel, first_value,
                  second_value, aux_value, delta_ticks, absolute_ticks,
                  sole_channel, last_of_run,
                  input ready);
  modport sink   (input valid, kind, track_tag, status, channel, first_value,
                  second_value, aux_value, delta_ticks, absolute_ticks,
                  sole_channel, last_of_run,
                  output ready);
endinterface

// ===== design/midi_track_event_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses Standard MIDI File track bytes into channel, tempo, time-signature
// and track summary records.
// ----------------------------------------------------------------------------
// Flow: a byte transfer is registered in the input stage, parsed once two
//   queue slots are free, and its records are offered from the queue head.
// Throughput: one byte per cycle while two queue slots are free; a byte
//   causing two records (an event on the track_end byte) needs two output
//   transfers, set by the single read port of the four-entry result queue.
// Reset: synchronous active-low rst_n clears the input stage, the queue and
//   all parse state; the parser then expects a delta time.
module midi_track_event_parser import mtep_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  mtep_in_if.sink    in_ch,
  mtep_out_if.source out_ch
);

  // Input stage: holds one byte until the queue has room for its records.
  logic        in_v_r, in_v_nxt;
  logic [7:0]  byte_r;
  logic        start_r;
  logic        end_r;
  logic [15:0] id_r;

  logic  room2;
  logic  go;
  logic  in_xfer;
  push_t push;
  rec_t  rd_rec;

  // Parse the held byte only when two queue slots are free.
  assign go       = in_v_r && room2;
  assign in_ch.ready = !in_v_r || go;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  always_comb begin
    priority if (in_xfer) begin
      in_v_nxt = 1'b1;
    end else if (go) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  // Payload of the input stage: load on every transfer, no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r  <= in_ch.data_byte;
      start_r <= in_ch.track_start;
      end_r   <= in_ch.track_end;
      id_r    <= in_ch.track_id;
    end
  end

  // Parser: advances the track state and forms the records of this byte.
  mtep_parser #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .data_byte   (byte_r),
    .track_start (start_r),
    .track_end   (end_r),
    .track_id    (id_r),
    .push        (push)
  );

  // Result queue: decouples record production from output stalls.
  mtep_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room2    (room2),
    .rd_valid (out_ch.valid),
    .rd_ready (out_ch.ready),
    .rd_rec   (rd_rec)
  );

  // Drive the result channel from the head of the queue.
  assign out_ch.kind           = rd_rec.kind;
  assign out_ch.track_tag      = rd_rec.track_tag;
  assign out_ch.status         = rd_rec.status;
  assign out_ch.channel        = rd_rec.channel;
  assign out_ch.first_value    = rd_rec.first_value;
  assign out_ch.second_value   = rd_rec.second_value;
  assign out_ch.aux_value      = rd_rec.aux_value;
  assign out_ch.delta_ticks    = rd_rec.delta_ticks;
  assign out_ch.absolute_ticks = rd_rec.absolute_ticks;
  assign out_ch.sole_channel   = rd_rec.sole_channel;
  assign out_ch.last_of_run    = rd_rec.last_of_run;

endmodule

// ===== design/mtep_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Per-track parse state; decodes one byte per go and forms up to two records.
// ----------------------------------------------------------------------------
module mtep_parser import mtep_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [7:0]  data_byte,
  input  logic        track_start,
  input  logic        track_end,
  input  logic [15:0] track_id,
  output push_t       push
);

  phase_t                phase_r, phase_b, phase_nxt;
  logic [27:0]           acc_r, acc_b, acc_nxt;
  logic [7:0]            rs_r, rs_b, rs_nxt;
  logic [7:0]            cur_r, cur_b, cur_nxt;
  logic [7:0]            meta_r, meta_b, meta_nxt;
  logic [27:0]           skip_r, skip_b, skip_nxt;
  logic [1:0]            bi_r, bi_b, bi_nxt;
  logic [13:0]           hf_r, hf_b, hf_nxt;
  logic [6:0]            hs_r, hs_b, hs_nxt;
  logic [23:0]           ha_r, ha_b, ha_nxt;
  logic [TIME_WIDTH-1:0] ts_r, ts_b, ts_nxt;
  logic [15:0]           seen_r, seen_b, seen_nxt;
  logic                  fin_r, fin_b, fin_nxt;

  logic        ev_valid;
  logic [1:0]  ev_kind;
  logic [7:0]  ev_status;
  logic [3:0]  ev_chan;
  logic [13:0] ev_v1;
  logic [6:0]  ev_v2;
  logic [23:0] ev_aux;
  logic        done;
  logic [6:0]  b7;
  logic [3:0]  sole_idx;
  logic        sole_one;
  rec_t        ev_rec, sum_rec;

  assign b7 = data_byte[6:0];

  always_comb begin
    // start of a track clears everything before the byte is parsed
    if (track_start) begin
      phase_b = PH_DELTA_FIRST; acc_b = '0; rs_b = '0; cur_b = '0; meta_b = '0;
      skip_b = '0; bi_b = '0; hf_b = '0; hs_b = '0; ha_b = '0; ts_b = '0;
      seen_b = '0; fin_b = 1'b0;
    end else begin
      phase_b = phase_r; acc_b = acc_r; rs_b = rs_r; cur_b = cur_r; meta_b = meta_r;
      skip_b = skip_r; bi_b = bi_r; hf_b = hf_r; hs_b = hs_r; ha_b = ha_r;
      ts_b = ts_r; seen_b = seen_r; fin_b = fin_r;
    end

    phase_nxt = phase_b; acc_nxt = acc_b; rs_nxt = rs_b; cur_nxt = cur_b;
    meta_nxt = meta_b; skip_nxt = skip_b; bi_nxt = bi_b; hf_nxt = hf_b;
    hs_nxt = hs_b; ha_nxt = ha_b; ts_nxt = ts_b; seen_nxt = seen_b; fin_nxt = fin_b;

    ev_valid = 1'b0; ev_kind = KIND_CHANNEL; ev_status = '0; ev_chan = '0;
    ev_v1 = '0; ev_v2 = '0; ev_aux = '0; done = 1'b0;

    if (!fin_b) begin
      unique case (phase_b)
        PH_DELTA_FIRST, PH_DELTA_MORE: begin
          if (phase_b == PH_DELTA_FIRST) begin
            acc_nxt = {21'd0, b7};
          end else begin
            acc_nxt = {acc_b[20:0], b7};
          end
          if (data_byte[7]) begin
            phase_nxt = PH_DELTA_MORE;
          end else begin
            ts_nxt    = ts_b + TIME_WIDTH'(acc_nxt);
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (data_byte[7:4] == HI_SYSTEM) begin
            skip_nxt = '0;
            priority if (data_byte == ST_META) begin
              phase_nxt = PH_META_TYPE;
            end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_ESC) begin
              phase_nxt = PH_SYSEX_LEN;
            end else if (data_byte == ST_MTC_QF || data_byte == ST_SONG_SEL) begin
              skip_nxt = 28'd1; phase_nxt = PH_SKIP;
            end else if (data_byte == ST_SONG_POS) begin
              skip_nxt = 28'd2; phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_DELTA_FIRST;
            end
          end else if (data_byte[7]) begin
            rs_nxt    = data_byte;
            cur_nxt   = data_byte;
            seen_nxt  = seen_b | (16'd1 << data_byte[3:0]);
            phase_nxt = PH_DATA1;
          end else if (rs_b != 8'd0) begin
            // running status: this byte is the first data byte
            cur_nxt  = rs_b;
            seen_nxt = seen_b | (16'd1 << rs_b[3:0]);
            hf_nxt   = {7'd0, b7};
            if (rs_b[7:4] == HI_PROGRAM || rs_b[7:4] == HI_CH_PRESS) begin
              ev_valid = 1'b1; ev_v1 = {7'd0, b7}; phase_nxt = PH_DELTA_FIRST;
            end else begin
              phase_nxt = PH_DATA2;
            end
          end else begin
            phase_nxt = PH_DELTA_FIRST;
          end
        end
        PH_DATA1: begin
          hf_nxt = {7'd0, b7};
          if (cur_b[7:4] == HI_PROGRAM || cur_b[7:4] == HI_CH_PRESS) begin
            ev_valid = 1'b1; ev_v1 = {7'd0, b7}; phase_nxt = PH_DELTA_FIRST;
          end else begin
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          ev_valid  = 1'b1;
          phase_nxt = PH_DELTA_FIRST;
          if (cur_b[7:4] == HI_BEND) begin
            ev_v1 = {b7, 7'd0} | hf_b;
          end else begin
            ev_v1 = hf_b;
            ev_v2 = b7;
          end
        end
        PH_META_TYPE: begin
          meta_nxt  = data_byte;
          skip_nxt  = '0;
          phase_nxt = PH_META_LEN;
        end
        PH_META_LEN: begin
          skip_nxt = {skip_b[20:0], b7};
          if (!data_byte[7]) begin
            priority if (meta_b == META_EOT) begin
              fin_nxt = 1'b1; phase_nxt = PH_DELTA_FIRST;
            end else if (skip_nxt == 28'd0) begin
              phase_nxt = PH_DELTA_FIRST;
            end else if (meta_b == META_TEMPO || meta_b == META_TIMESIG) begin
              bi_nxt = '0; hf_nxt = '0; hs_nxt = '0; ha_nxt = '0;
              phase_nxt = PH_META_BODY;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_META_BODY: begin
          skip_nxt = skip_b - 28'd1;
          if (meta_b == META_TEMPO) begin
            ha_nxt = {ha_b[15:0], data_byte};
            if (bi_b == 2'd2) begin
              ev_valid = 1'b1; ev_kind = KIND_TEMPO; ev_aux = ha_nxt; done = 1'b1;
            end
          end else begin
            unique case (bi_b)
              2'd0: hf_nxt = {6'd0, data_byte};
              2'd1: hs_nxt = b7;
              2'd2: ha_nxt = {8'd0, data_byte, 8'd0};
              default: begin
                ha_nxt   = ha_b | {16'd0, data_byte};
                ev_valid = 1'b1; ev_kind = KIND_TIMESIG;
                ev_v1 = hf_b; ev_v2 = hs_b; ev_aux = ha_nxt; done = 1'b1;
              end
            endcase
          end
          bi_nxt = bi_b + 2'd1;
          if (skip_nxt == 28'd0) begin
            phase_nxt = PH_DELTA_FIRST;
          end else if (done) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_b - 28'd1;
          if (skip_nxt == 28'd0) begin
            phase_nxt = PH_DELTA_FIRST;
          end
        end
        PH_SYSEX_LEN: begin
          skip_nxt = {skip_b[20:0], b7};
          if (!data_byte[7]) begin
            phase_nxt = (skip_nxt == 28'd0) ? PH_DELTA_FIRST : PH_SKIP;
          end
        end
        default: phase_nxt = PH_DELTA_FIRST;
      endcase
    end

    if (ev_kind == KIND_CHANNEL) begin
      ev_status = cur_nxt;
      ev_chan   = cur_nxt[3:0];
    end else if (ev_kind == KIND_TEMPO) begin
      ev_status = META_TEMPO;
    end else begin
      ev_status = META_TIMESIG;
    end

    if (track_end) begin
      fin_nxt = 1'b1;
    end
  end

  // sole channel: one bit set in the channel mask
  always_comb begin
    sole_idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (seen_nxt[i]) begin
        sole_idx = 4'(i);
      end
    end
    sole_one = (seen_nxt != 16'd0) && ((seen_nxt & (seen_nxt - 16'd1)) == 16'd0);
  end

  always_comb begin
    ev_rec.kind           = ev_kind;
    ev_rec.track_tag      = track_id;
    ev_rec.status         = ev_status;
    ev_rec.channel        = ev_chan;
    ev_rec.first_value    = ev_v1;
    ev_rec.second_value   = ev_v2;
    ev_rec.aux_value      = ev_aux;
    ev_rec.delta_ticks    = acc_nxt;
    ev_rec.absolute_ticks = 32'(ts_nxt);
    ev_rec.sole_channel   = NO_SOLE;
    ev_rec.last_of_run    = !track_end;

    sum_rec.kind           = KIND_SUMMARY;
    sum_rec.track_tag      = track_id;
    sum_rec.status         = '0;
    sum_rec.channel        = '0;
    sum_rec.first_value    = '0;
    sum_rec.second_value   = '0;
    sum_rec.aux_value      = '0;
    sum_rec.delta_ticks    = '0;
    sum_rec.absolute_ticks = 32'(ts_nxt);
    sum_rec.sole_channel   = sole_one ? {1'b0, sole_idx} : NO_SOLE;
    sum_rec.last_of_run    = 1'b1;

    push.push0 = go && (ev_valid || track_end);
    push.push1 = go && ev_valid && track_end;
    push.rec0  = ev_valid ? ev_rec : sum_rec;
    push.rec1  = sum_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA_FIRST; acc_r <= '0; rs_r <= '0; cur_r <= '0; meta_r <= '0;
      skip_r <= '0; bi_r <= '0; hf_r <= '0; hs_r <= '0; ha_r <= '0; ts_r <= '0;
      seen_r <= '0; fin_r <= 1'b0;
    end else if (go) begin
      phase_r <= phase_nxt; acc_r <= acc_nxt; rs_r <= rs_nxt; cur_r <= cur_nxt;
      meta_r <= meta_nxt; skip_r <= skip_nxt; bi_r <= bi_nxt; hf_r <= hf_nxt;
      hs_r <= hs_nxt; ha_r <= ha_nxt; ts_r <= ts_nxt; seen_r <= seen_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule

// ===== design/mtep_out_fifo.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser result queue
// Four-entry record queue: two writes, one read per cycle.
// ----------------------------------------------------------------------------
module mtep_out_fifo import mtep_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room2,
  output logic  rd_valid,
  input  logic  rd_ready,
  output rec_t  rd_rec
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          pop;

  assign rd_valid = (count_r != '0);
  assign rd_rec   = mem_r[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;
  assign room2    = (count_r <= (PW+1)'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.push0) + PW'(push.push1);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + (PW+1)'(push.push0) + (PW+1)'(push.push1) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.rec0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_r + PW'(1)] <= push.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/mtep_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mtep_checker import mtep_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_status,
  input logic [3:0]  out_channel,
  input logic [4:0]  out_sole_channel,
  input logic        out_last_of_run
);

  // a pending record stays offered until transferred
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // nothing is offered in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // summary closes the run of its byte; other records carry no sole channel
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_SUMMARY) |-> out_last_of_run)
    else $error("summary not last of run");

  a_sole_only_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_SUMMARY) |-> (out_sole_channel == NO_SOLE))
    else $error("sole channel set on a non-summary record");

  // channel events carry a channel status byte and its low nibble
  a_channel_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CHANNEL) |->
      out_status[7] && (out_status[7:4] != HI_SYSTEM) &&
      (out_channel == out_status[3:0]))
    else $error("channel event with bad status or channel");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_status       (out_ch.status),
  .out_channel      (out_ch.channel),
  .out_sole_channel (out_ch.sole_channel),
  .out_last_of_run  (out_ch.last_of_run)
);

// ===== tb/mtep_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser record checker
// Watches the byte and record channels, parses every accepted byte in step
// with the block and compares each record transfer field by field.
// ----------------------------------------------------------------------------
module mtep_record_checker import mtep_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mtep_in_if   in_ch,
  mtep_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  rec_t expected_records[$];
  rec_t byte_records[$];
  rec_t got_rec;

  // parser state as the block should hold it
  phase_t      ph;
  logic [27:0] dt_acc;
  logic [7:0]  run_st;
  logic [7:0]  cur_st;
  logic [7:0]  meta_type;
  logic [27:0] bytes_left;
  logic [1:0]  body_pos;
  logic [13:0] hold_v1;
  logic [6:0]  hold_v2;
  logic [23:0] hold_aux;
  logic [31:0] abs_time;
  logic [15:0] ch_mask;
  logic        trk_done;

  function automatic void clear_track_state();
    ph = PH_DELTA_FIRST;
    dt_acc = '0; run_st = '0; cur_st = '0; meta_type = '0;
    bytes_left = '0; body_pos = '0; hold_v1 = '0; hold_v2 = '0;
    hold_aux = '0; abs_time = '0; ch_mask = '0; trk_done = 1'b0;
  endfunction

  function automatic rec_t build_record(kind_t k, logic [15:0] tag, logic [7:0] st,
                                        logic [3:0] ch, logic [13:0] v1, logic [6:0] v2,
                                        logic [23:0] aux, logic [27:0] dt,
                                        logic [4:0] sole);
    rec_t r;
    r.kind           = k;
    r.track_tag      = tag;
    r.status         = st;
    r.channel        = ch;
    r.first_value    = v1;
    r.second_value   = v2;
    r.aux_value      = aux;
    r.delta_ticks    = dt;
    r.absolute_ticks = abs_time;
    r.sole_channel   = sole;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  // append one record to those of the current byte
  function automatic void add_byte_record(rec_t r);
    byte_records = {byte_records, r};
  endfunction

  function automatic void emit_channel_event(logic [15:0] tag, logic [13:0] v1,
                                             logic [6:0] v2);
    add_byte_record(build_record(KIND_CHANNEL, tag, cur_st, cur_st[3:0], v1, v2,
                                 24'd0, dt_acc, NO_SOLE));
    ph = PH_DELTA_FIRST;
  endfunction

  // program change and channel pressure complete on their single data byte
  function automatic void take_first_data(logic [15:0] tag, logic [7:0] b);
    hold_v1 = {7'd0, b[6:0]};
    if (cur_st[7:4] == HI_PROGRAM || cur_st[7:4] == HI_CH_PRESS)
      emit_channel_event(tag, hold_v1, 7'd0);
    else
      ph = PH_DATA2;
  endfunction

  function automatic void parse_track_byte(logic [7:0] b, logic ts, logic te,
                                           logic [15:0] tag);
    int          n_used;
    logic [4:0]  sole;
    logic        rec_done;
    rec_t        r;
    byte_records.delete();
    if (ts)
      clear_track_state();
    if (!trk_done) begin
      case (ph)
        PH_DELTA_FIRST, PH_DELTA_MORE: begin
          if (ph == PH_DELTA_FIRST)
            dt_acc = {21'd0, b[6:0]};
          else
            dt_acc = {dt_acc[20:0], b[6:0]};
          if (b[7]) begin
            ph = PH_DELTA_MORE;
          end else begin
            abs_time = abs_time + 32'(dt_acc);
            ph = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7:4] == HI_SYSTEM) begin
            bytes_left = '0;
            if (b == ST_META) begin
              ph = PH_META_TYPE;
            end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
              ph = PH_SYSEX_LEN;
            end else if (b == ST_MTC_QF || b == ST_SONG_SEL) begin
              bytes_left = 28'd1;
              ph = PH_SKIP;
            end else if (b == ST_SONG_POS) begin
              bytes_left = 28'd2;
              ph = PH_SKIP;
            end else begin
              ph = PH_DELTA_FIRST;
            end
          end else if (b[7]) begin
            run_st = b;
            cur_st = b;
            ch_mask[b[3:0]] = 1'b1;
            ph = PH_DATA1;
          end else if (run_st != 8'd0) begin
            cur_st = run_st;
            ch_mask[cur_st[3:0]] = 1'b1;
            take_first_data(tag, b);
          end else begin
            ph = PH_DELTA_FIRST;
          end
        end
        PH_DATA1: take_first_data(tag, b);
        PH_DATA2: begin
          if (cur_st[7:4] == HI_BEND)
            emit_channel_event(tag, {b[6:0], hold_v1[6:0]}, 7'd0);
          else
            emit_channel_event(tag, hold_v1, b[6:0]);
        end
        PH_META_TYPE: begin
          meta_type = b;
          bytes_left = '0;
          ph = PH_META_LEN;
        end
        PH_META_LEN: begin
          bytes_left = {bytes_left[20:0], b[6:0]};
          if (!b[7]) begin
            if (meta_type == META_EOT) begin
              trk_done = 1'b1;
              ph = PH_DELTA_FIRST;
            end else if (bytes_left == 28'd0) begin
              ph = PH_DELTA_FIRST;
            end else if (meta_type == META_TEMPO || meta_type == META_TIMESIG) begin
              body_pos = '0; hold_v1 = '0; hold_v2 = '0; hold_aux = '0;
              ph = PH_META_BODY;
            end else begin
              ph = PH_SKIP;
            end
          end
        end
        PH_META_BODY: begin
          rec_done = 1'b0;
          bytes_left = bytes_left - 28'd1;
          if (meta_type == META_TEMPO) begin
            hold_aux = {hold_aux[15:0], b};
            if (body_pos == 2'd2) begin
              add_byte_record(build_record(KIND_TEMPO, tag, META_TEMPO, 4'd0, 14'd0,
                                           7'd0, hold_aux, dt_acc, NO_SOLE));
              rec_done = 1'b1;
            end
          end else begin
            case (body_pos)
              2'd0: hold_v1 = {6'd0, b};
              2'd1: hold_v2 = b[6:0];
              2'd2: hold_aux = {8'd0, b, 8'd0};
              default: begin
                hold_aux = hold_aux | {16'd0, b};
                add_byte_record(build_record(KIND_TIMESIG, tag, META_TIMESIG, 4'd0,
                                             hold_v1, hold_v2, hold_aux, dt_acc,
                                             NO_SOLE));
                rec_done = 1'b1;
              end
            endcase
          end
          body_pos = body_pos + 2'd1;
          if (bytes_left == 28'd0)
            ph = PH_DELTA_FIRST;
          else if (rec_done)
            ph = PH_SKIP;
        end
        PH_SKIP: begin
          bytes_left = bytes_left - 28'd1;
          if (bytes_left == 28'd0)
            ph = PH_DELTA_FIRST;
        end
        PH_SYSEX_LEN: begin
          bytes_left = {bytes_left[20:0], b[6:0]};
          if (!b[7])
            ph = (bytes_left == 28'd0) ? PH_DELTA_FIRST : PH_SKIP;
        end
        default: ph = PH_DELTA_FIRST;
      endcase
    end
    // the summary goes out on every track_end byte, finished or not
    if (te) begin
      n_used = 0;
      sole = NO_SOLE;
      for (int i = 0; i < 16; i++) begin
        if (ch_mask[i]) begin
          n_used++;
          sole = 5'(i);
        end
      end
      if (n_used != 1)
        sole = NO_SOLE;
      add_byte_record(build_record(KIND_SUMMARY, tag, 8'd0, 4'd0, 14'd0, 7'd0,
                                   24'd0, 28'd0, sole));
      trk_done = 1'b1;
    end
    foreach (byte_records[i]) begin
      r = byte_records[i];
      r.last_of_run = (i == byte_records.size() - 1);
      expected_records = {expected_records, r};
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_track_state();
      expected_records.delete();
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        parse_track_byte(in_ch.data_byte, in_ch.track_start, in_ch.track_end,
                         in_ch.track_id);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_records.size() == 0) begin
          $error("record transfer with nothing expected: kind %0d tag 0x%0h",
                 out_ch.kind, out_ch.track_tag);
          fail_count++;
        end else begin
          got_rec = expected_records.pop_front();
          check_field("kind",           32'(got_rec.kind),           32'(out_ch.kind));
          check_field("track_tag",      32'(got_rec.track_tag),      32'(out_ch.track_tag));
          check_field("status",         32'(got_rec.status),         32'(out_ch.status));
          check_field("channel",        32'(got_rec.channel),        32'(out_ch.channel));
          check_field("first_value",    32'(got_rec.first_value),    32'(out_ch.first_value));
          check_field("second_value",   32'(got_rec.second_value),   32'(out_ch.second_value));
          check_field("aux_value",      32'(got_rec.aux_value),      32'(out_ch.aux_value));
          check_field("delta_ticks",    32'(got_rec.delta_ticks),    32'(out_ch.delta_ticks));
          check_field("absolute_ticks", got_rec.absolute_ticks,      out_ch.absolute_ticks);
          check_field("sole_channel",   32'(got_rec.sole_channel),   32'(out_ch.sole_channel));
          check_field("last_of_run",    32'(got_rec.last_of_run),    32'(out_ch.last_of_run));
        end
      end
    end
    pending = expected_records.size();
  end

endmodule

// ===== tb/tb_midi_track_event_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Feeds whole tracks of Standard MIDI File bytes, a few hand-built and the
// rest random but mostly well formed, with bursty input and a stalling
// record receiver. The record checker predicts and compares; this module
// drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser import mtep_pkg::*;;

  localparam int BYTE_TARGET = 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   bytes_sent;
  int   burst_left;
  int   stall_left;
  int   recv_mode;
  int   mode_left;

  logic [7:0] track_q[$];

  mtep_in_if  in_ch ();
  mtep_out_if out_ch ();

  midi_track_event_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mtep_record_checker record_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost record ends the run here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Record receiver: switch between always ready, coin-toss ready and
  // occasional long stalls, so back-pressure lands on every parse phase.
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
    recv_mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        recv_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (recv_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 9) == 0) begin
              stall_left = $urandom_range(1, 8);
              out_ch.ready <= 1'b0;
            end else begin
              out_ch.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Offer one byte and hold it until the transfer. Called at a falling edge
  // and returns at a falling edge; valid stays high across a burst.
  task automatic send_byte(input logic [7:0] b, input logic ts, input logic te,
                           input logic [15:0] id);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.track_start <= ts;
    in_ch.track_end   <= te;
    in_ch.track_id    <= id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Send the assembled track; flag the first byte, and the last if asked.
  task automatic send_track(input logic [15:0] id, input logic ends);
    foreach (track_q[i])
      send_byte(track_q[i], i == 0, ends && (i == track_q.size() - 1), id);
  endtask

  // Add one byte to the end of the track being built.
  function automatic void append_byte(logic [7:0] b);
    track_q = {track_q, b};
  endfunction

  // Append a variable-length quantity in exactly nbytes groups, high first.
  function automatic void put_vlq(logic [31:0] v, int nbytes);
    logic [6:0] grp;
    for (int i = nbytes - 1; i >= 0; i--) begin
      grp = 7'(v >> (7 * i));
      append_byte({i > 0, grp});
    end
  endfunction

  // Short lengths, sometimes padded, sometimes with bits set above the low 28.
  function automatic void put_length(int unsigned len);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80)
      put_vlq(len, 1);
    else if (sel < 92)
      put_vlq(len, 2);
    else
      put_vlq({4'($urandom_range(1, 15)), 28'(len)}, 5);
  endfunction

  function automatic void put_delta(logic big);
    int sel;
    sel = $urandom_range(0, 99);
    if (big)
      put_vlq(32'h0FFF_FFFF, 4);
    else if (sel < 70)
      put_vlq($urandom_range(0, 127), 1);
    else if (sel < 88)
      put_vlq($urandom_range(0, 16383), 2);
    else if (sel < 96)
      put_vlq($urandom, $urandom_range(3, 4));
    else
      put_vlq($urandom, 5);
  endfunction

  // Mostly clean 7-bit data, now and then with the high bit set.
  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 9) == 0)
      return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic void put_channel_data(logic [7:0] st);
    append_byte(rand_data());
    if (st[7:4] != HI_PROGRAM && st[7:4] != HI_CH_PRESS)
      append_byte(rand_data());
  endfunction

  function automatic void put_body(int unsigned len, logic full_range);
    repeat (len)
      append_byte(full_range ? 8'($urandom) : 8'($urandom_range(0, 127)));
  endfunction

  function automatic void put_meta(logic [7:0] mtype, int unsigned len);
    append_byte(ST_META);
    append_byte(mtype);
    put_length(len);
    put_body(len, 1'b1);
  endfunction

  // Build and send one random track. Most events are well formed so the
  // parser gets deep into bodies; a few stray bytes knock it off course.
  task automatic random_track();
    int          nev;
    int          sel;
    int          n_trail;
    int          len;
    logic [15:0] id;
    logic        big;
    logic        have_rs;
    logic [7:0]  last_st;
    logic [7:0]  st;
    track_q.delete();
    sel = $urandom_range(0, 9);
    id = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom);
    big = ($urandom_range(0, 19) == 0);
    nev = big ? 20 : $urandom_range(1, 12);
    have_rs = 1'b0;
    last_st = 8'h80;
    repeat (nev) begin
      put_delta(big);
      sel = $urandom_range(0, 99);
      if (sel < 35 || (sel < 55 && !have_rs)) begin
        // keep to one channel sometimes so a sole channel shows up
        st = 8'($urandom_range(8'h80, 8'hEF));
        if ($urandom_range(0, 1) == 0)
          st[3:0] = id[3:0];
        append_byte(st);
        put_channel_data(st);
        last_st = st;
        have_rs = 1'b1;
      end else if (sel < 55) begin
        put_channel_data(last_st);
      end else if (sel < 63) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : 3;
        put_meta(META_TEMPO, len);
      end else if (sel < 71) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 4;
        put_meta(META_TIMESIG, len);
      end else if (sel < 77) begin
        put_meta(8'($urandom), $urandom_range(0, 5));
      end else if (sel < 83) begin
        append_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
        len = $urandom_range(0, 6);
        put_length(len);
        put_body(len, 1'b0);
      end else if (sel < 91) begin
        st = 8'($urandom_range(8'hF1, 8'hFE));
        if (st == ST_SYSEX_ESC)
          st = ST_SONG_POS;
        append_byte(st);
        if (st == ST_MTC_QF || st == ST_SONG_SEL)
          put_body(1, 1'b0);
        else if (st == ST_SONG_POS)
          put_body(2, 1'b0);
      end else if (sel < 96) begin
        append_byte(8'($urandom));
      end else begin
        // end of track in the middle: the rest must be ignored
        put_meta(META_EOT, 0);
      end
    end
    if ($urandom_range(0, 9) < 6) begin
      put_delta(1'b0);
      put_meta(META_EOT, 0);
    end
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      send_track(id, 1'b1);
    end else if (sel < 85) begin
      // abandon the track: the next track_start must clear it
      send_track(id, 1'b0);
    end else begin
      // bytes after the end, the last one closing the track again
      send_track(id, 1'b1);
      n_trail = $urandom_range(1, 3);
      for (int i = 0; i < n_trail; i++)
        send_byte(8'($urandom), 1'b0, i == n_trail - 1, id);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'd0;
    in_ch.track_start = 1'b0;
    in_ch.track_end   = 1'b0;
    in_ch.track_id    = 16'd0;
    bytes_sent        = 0;
    burst_left        = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed track: program change at full key, two-byte delta into a
    // pitch bend at full msb, a tempo record, then a time signature whose
    // last body byte is also the track end, giving two records at once.
    track_q = '{8'h00, {HI_PROGRAM, 4'h5}, 8'h7F,
                8'h81, 8'h00, {HI_BEND, 4'h5}, 8'h00, 8'h7F,
                8'h00, ST_META, META_TEMPO, 8'h03, 8'h07, 8'hA1, 8'h20,
                8'h00, ST_META, META_TIMESIG, 8'h04, 8'hFF, 8'h03, 8'h18, 8'h08};
    send_track(16'h0000, 1'b1);
    // Data byte with no running status: drop it, summary shows no channel.
    track_q = '{8'h00, 8'h40};
    send_track(16'hFFFF, 1'b1);

    while (bytes_sent < BYTE_TARGET)
      random_track();

    // Drain: wait for every predicted record, then let the pipe settle.
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/mtep_pkg.sv
design/mtep_if.sv
design/mtep_parser.sv
design/mtep_out_fifo.sv
design/midi_track_event_parser.sv
design/mtep_checker.sv
tb/mtep_record_checker.sv
tb/tb_midi_track_event_parser.sv
